// ===== design/ddo_pkg.sv =====
`default_nettype none
package ddo_pkg;

  localparam int unsigned CntW  = 32;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned CordW = 34;
  localparam int unsigned MulW  = 34;

  localparam logic [IdxW-1:0] REG_LEFT_TICK  = 2'd0;
  localparam logic [IdxW-1:0] REG_RIGHT_TICK = 2'd1;
  localparam logic [IdxW-1:0] REG_TURN_GAIN  = 2'd2;

  localparam logic [31:0] LEFT_TICK_RST  = 32'd52472800;
  localparam logic [31:0] RIGHT_TICK_RST = 32'd52472800;
  localparam logic [31:0] TURN_GAIN_RST  = 32'd30201959;
  localparam logic [CordW-1:0] CORDIC_GAIN = 34'd652032874;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_INIT, ST_ROT, ST_POST, ST_UPD
  } state_e;

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD, OP_PRE, OP_INIT, OP_ROT, OP_POST, OP_UPD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic func;
  } sts_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/ddo_in_if.sv =====
`default_nettype none
interface ddo_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] left_count;
  logic [31:0] right_count;
  modport source (output valid, func, left_count, right_count, input ready);
  modport sink   (input valid, func, left_count, right_count, output ready);
endinterface
`default_nettype wire

// ===== design/ddo_out_if.sv =====
`default_nettype none
interface ddo_out_if #(parameter int unsigned POSE_WIDTH = 48);
  logic                  valid;
  logic                  ready;
  logic [POSE_WIDTH-1:0] pos_x;
  logic [POSE_WIDTH-1:0] pos_y;
  logic [31:0]           heading;
  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface
`default_nettype wire

// ===== design/differential_drive_odometry_unit.sv =====
// A start item clears the pose and latches its counts; a step item takes four products
// on one shared multiplier, one CORDIC rotation per cycle, four more products, then the
// update. The update waits until the result register is free. A new item is taken only
// after the previous one has made its update; the next transfer is taken while the result
// waits. Reset clears the pose and the latched counts and returns the registers to their
// default values.
`default_nettype none
module differential_drive_odometry_unit #(
  parameter int unsigned CORDIC_STEPS = 24,
  parameter int unsigned POSE_WIDTH   = 48
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire  [ddo_pkg::IdxW-1:0] cfg_idx_i,
  input  wire  [31:0]              cfg_data_i,
  ddo_in_if.sink                   in_i,
  ddo_out_if.source                out_o
);

  ddo_pkg::cmd_t cmd;
  ddo_pkg::sts_t sts;

  ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ddo_datapath #(.POSE_WIDTH(POSE_WIDTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_func_i  (in_i.func),
    .in_left_i  (in_i.left_count),
    .in_right_i (in_i.right_count),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .pos_x_o    (out_o.pos_x),
    .pos_y_o    (out_o.pos_y),
    .heading_o  (out_o.heading)
  );

endmodule
`default_nettype wire

// ===== design/ddo_ctrl.sv =====
`default_nettype none
module ddo_ctrl #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  input  wire ddo_pkg::sts_t sts_i,
  output ddo_pkg::cmd_t    cmd_o
);

  localparam int unsigned CntW = $clog2(CORDIC_STEPS);
  localparam logic [CntW-1:0] CntLast = CntW'(CORDIC_STEPS - 1);
  localparam logic [CntW-1:0] MulLast = CntW'(3);

  ddo_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ddo_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ddo_pkg::ST_PRE;
          cnt_d   = '0;
        end
      end
      ddo_pkg::ST_PRE: begin
        if (!sts_i.func) begin
          state_d = ddo_pkg::ST_UPD;
        end else if (cnt_q == MulLast) begin
          state_d = ddo_pkg::ST_INIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ddo_pkg::ST_INIT: begin
        state_d = ddo_pkg::ST_ROT;
        cnt_d   = '0;
      end
      ddo_pkg::ST_ROT: begin
        if (cnt_q == CntLast) begin
          state_d = ddo_pkg::ST_POST;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ddo_pkg::ST_POST: begin
        if (cnt_q == MulLast) begin
          state_d = ddo_pkg::ST_UPD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ddo_pkg::ST_UPD: begin
        // hold until the result register is free
        if (out_free) begin
          state_d = ddo_pkg::ST_IDLE;
        end
      end
      default: state_d = ddo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.op    = ddo_pkg::OP_NOP;
    cmd_o.idx   = 5'(cnt_q);
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ddo_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = ddo_pkg::OP_LOAD;
      end
      ddo_pkg::ST_PRE: begin
        if (sts_i.func) cmd_o.op = ddo_pkg::OP_PRE;
      end
      ddo_pkg::ST_INIT: cmd_o.op = ddo_pkg::OP_INIT;
      ddo_pkg::ST_ROT:  cmd_o.op = ddo_pkg::OP_ROT;
      ddo_pkg::ST_POST: cmd_o.op = ddo_pkg::OP_POST;
      ddo_pkg::ST_UPD: begin
        if (out_free) begin
          cmd_o.op    = ddo_pkg::OP_UPD;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o.op = ddo_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ddo_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== design/ddo_datapath.sv =====
`default_nettype none
module ddo_datapath #(
  parameter int unsigned POSE_WIDTH = 48
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [ddo_pkg::IdxW-1:0]     cfg_idx_i,
  input  wire  [31:0]                  cfg_data_i,
  input  wire                          in_func_i,
  input  wire  [31:0]                  in_left_i,
  input  wire  [31:0]                  in_right_i,
  input  wire  ddo_pkg::cmd_t          cmd_i,
  output ddo_pkg::sts_t                sts_o,
  output logic [POSE_WIDTH-1:0]        pos_x_o,
  output logic [POSE_WIDTH-1:0]        pos_y_o,
  output logic [31:0]                  heading_o
);

  localparam int unsigned CW = ddo_pkg::CordW;
  localparam int unsigned MW = ddo_pkg::MulW;
  localparam int unsigned PW = 2 * MW;
  localparam int unsigned SW = 66;
  localparam logic signed [SW-1:0] PoseMax = SW'((68'sd1 <<< (POSE_WIDTH - 1)) - 68'sd1);
  localparam logic signed [SW-1:0] PoseMin = -PoseMax - SW'(1);

  logic [31:0] left_tick_q, right_tick_q, gain_q;
  logic        func_q;
  logic [31:0] lc_q, rc_q, last_left_q, last_right_q;
  logic [63:0] len_l_q, len_r_q, plo_q;
  logic [31:0] phi_q, dth_q, heading_q;
  logic [56:0] travel_q;
  logic signed [CW-1:0] x_q, y_q, z_q;
  logic        neg_q;
  logic signed [PW-1:0] xhi_q, xlo_q, yhi_q, ylo_q;
  logic signed [POSE_WIDTH-1:0] xacc_q, yacc_q;

  // shared multiplier
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [31:0] dl, dr;
  logic [63:0] diff;
  logic signed [CW-1:0] c_val, s_val;

  assign dl    = lc_q - last_left_q;
  assign dr    = rc_q - last_right_q;
  assign diff  = len_l_q - len_r_q;
  assign c_val = neg_q ? -x_q : x_q;
  assign s_val = neg_q ? -y_q : y_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == ddo_pkg::OP_PRE) begin
      case (cmd_i.idx[1:0])
        2'd0: begin
          mul_a = {{2{dl[31]}}, dl};
          mul_b = {2'b00, left_tick_q};
        end
        2'd1: begin
          mul_a = {{2{dr[31]}}, dr};
          mul_b = {2'b00, right_tick_q};
        end
        2'd2: begin
          mul_a = {2'b00, diff[31:0]};
          mul_b = {2'b00, gain_q};
        end
        default: begin
          mul_a = {2'b00, diff[63:32]};
          mul_b = {2'b00, gain_q};
        end
      endcase
    end else begin
      case (cmd_i.idx[1:0])
        2'd0: begin
          mul_a = MW'($signed(travel_q[56:32]));
          mul_b = c_val;
        end
        2'd1: begin
          mul_a = {2'b00, travel_q[31:0]};
          mul_b = c_val;
        end
        2'd2: begin
          mul_a = MW'($signed(travel_q[56:32]));
          mul_b = s_val;
        end
        default: begin
          mul_a = {2'b00, travel_q[31:0]};
          mul_b = s_val;
        end
      endcase
    end
  end

  assign prod = mul_a * mul_b;

  // midpoint angle and fold into the half turn about zero
  logic [31:0] dth_c, half_c, ang_c;
  logic signed [CW-1:0] ang_s, z_init;
  logic neg_init;
  logic signed [56:0] travel_c;

  always_comb begin
    dth_c   = plo_q[63:32] + phi_q;
    half_c  = {dth_c[31], dth_c[31:1]};
    ang_c   = heading_q + half_c;
    ang_s   = CW'($signed(ang_c));
    z_init  = ang_s;
    neg_init = 1'b0;
    if (ang_s > CW'(34'sh40000000)) begin
      z_init   = ang_s - CW'(34'sh80000000);
      neg_init = 1'b1;
    end else if (ang_s < -CW'(34'sh40000000)) begin
      z_init   = ang_s + CW'(34'sh80000000);
      neg_init = 1'b1;
    end
    travel_c = 57'(($signed(len_l_q[63:8]) + 57'($signed(len_r_q[63:8]))) >>> 1);
  end

  // rotation step
  logic signed [CW-1:0] x_sh, y_sh, ang_step;
  assign x_sh     = x_q >>> cmd_i.idx;
  assign y_sh     = y_q >>> cmd_i.idx;
  assign ang_step = CW'(ddo_pkg::atan_bam(cmd_i.idx));

  // pose update with saturation
  logic signed [SW-1:0] dx, dy, sx, sy;
  logic signed [POSE_WIDTH-1:0] xacc_d, yacc_d;
  logic [31:0] heading_d;

  always_comb begin
    dx = SW'(xhi_q <<< 2) + SW'(xlo_q >>> 30);
    dy = SW'(yhi_q <<< 2) + SW'(ylo_q >>> 30);
    sx = SW'(xacc_q) + dx;
    sy = SW'(yacc_q) + dy;
    if (sx > PoseMax)      xacc_d = POSE_WIDTH'(PoseMax);
    else if (sx < PoseMin) xacc_d = POSE_WIDTH'(PoseMin);
    else                   xacc_d = POSE_WIDTH'(sx);
    if (sy > PoseMax)      yacc_d = POSE_WIDTH'(PoseMax);
    else if (sy < PoseMin) yacc_d = POSE_WIDTH'(PoseMin);
    else                   yacc_d = POSE_WIDTH'(sy);
    heading_d = heading_q + dth_q;
    if (!func_q) begin
      xacc_d    = '0;
      yacc_d    = '0;
      heading_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_tick_q  <= ddo_pkg::LEFT_TICK_RST;
      right_tick_q <= ddo_pkg::RIGHT_TICK_RST;
      gain_q       <= ddo_pkg::TURN_GAIN_RST;
      last_left_q  <= '0;
      last_right_q <= '0;
      xacc_q       <= '0;
      yacc_q       <= '0;
      heading_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ddo_pkg::REG_LEFT_TICK:  left_tick_q  <= cfg_data_i;
          ddo_pkg::REG_RIGHT_TICK: right_tick_q <= cfg_data_i;
          ddo_pkg::REG_TURN_GAIN:  gain_q       <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == ddo_pkg::OP_UPD) begin
        last_left_q  <= lc_q;
        last_right_q <= rc_q;
        xacc_q       <= xacc_d;
        yacc_q       <= yacc_d;
        heading_q    <= heading_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ddo_pkg::OP_LOAD: begin
        func_q <= in_func_i;
        lc_q   <= in_left_i;
        rc_q   <= in_right_i;
      end
      ddo_pkg::OP_PRE: begin
        case (cmd_i.idx[1:0])
          2'd0:    len_l_q <= 64'(prod);
          2'd1:    len_r_q <= 64'(prod);
          2'd2:    plo_q   <= 64'(prod);
          default: phi_q   <= 32'(prod);
        endcase
      end
      ddo_pkg::OP_INIT: begin
        dth_q    <= dth_c;
        travel_q <= travel_c;
        x_q      <= ddo_pkg::CORDIC_GAIN;
        y_q      <= '0;
        z_q      <= z_init;
        neg_q    <= neg_init;
      end
      ddo_pkg::OP_ROT: begin
        if (!z_q[CW-1]) begin
          x_q <= x_q - y_sh;
          y_q <= y_q + x_sh;
          z_q <= z_q - ang_step;
        end else begin
          x_q <= x_q + y_sh;
          y_q <= y_q - x_sh;
          z_q <= z_q + ang_step;
        end
      end
      ddo_pkg::OP_POST: begin
        case (cmd_i.idx[1:0])
          2'd0:    xhi_q <= prod;
          2'd1:    xlo_q <= prod;
          2'd2:    yhi_q <= prod;
          default: ylo_q <= prod;
        endcase
      end
      ddo_pkg::OP_UPD: begin
        pos_x_o   <= xacc_d;
        pos_y_o   <= yacc_d;
        heading_o <= heading_d;
      end
      default: ;
    endcase
  end

  assign sts_o.func = func_q;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PoseW = 48;
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;
  localparam logic [ddo_pkg::IdxW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CordSteps = 24;
  localparam int unsigned StallLimit = 5000;
  localparam longint PoseMax = (longint'(1) <<< (PoseW - 1)) - 1;

  typedef struct {
    logic        func;
    logic [31:0] left_count;
    logic [31:0] right_count;
  } sample_t;

  typedef struct {
    logic [PoseW-1:0] pos_x;
    logic [PoseW-1:0] pos_y;
    logic [31:0]      heading;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [ddo_pkg::IdxW-1:0] cfg_idx;
  logic [31:0] cfg_data;

  ddo_in_if in_if ();
  ddo_out_if #(.POSE_WIDTH(PoseW)) out_if ();

  differential_drive_odometry_unit #(.CORDIC_STEPS(CordSteps), .POSE_WIDTH(PoseW)) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state
  logic [31:0] left_tick, right_tick, turn_gain;
  longint x_pos, y_pos;
  logic [31:0] heading_pos, prev_left, prev_right;

  sample_t sample_q[$];
  pose_t   pose_q[$];
  int      n_errors;
  int      idle_cycles;
  bit      no_idle;
  int      send_gap, recv_stall;
  logic [31:0] gen_left, gen_right;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint sat_add(longint acc, longint d);
    if (d > 0 && acc > PoseMax - d) return PoseMax;
    if (d < 0 && acc < -PoseMax - 1 - d) return -PoseMax - 1;
    return acc + d;
  endfunction

  // floor(a * c / 2^30) without leaving 64 bits
  function automatic longint scale_q30(longint a, longint c);
    longint hi, lo;
    hi = a >>> 32;
    lo = longint'({32'd0, a[31:0]});
    return hi * c * 4 + ((lo * c) >>> 30);
  endfunction

  function automatic void rotate(logic [31:0] ang, output longint cs, output longint sn);
    longint z, x, y, t, a;
    bit flip;
    z = longint'(signed'(ang));
    x = longint'(ddo_pkg::CORDIC_GAIN);
    y = 0;
    flip = 0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000; flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000; flip = 1;
    end
    for (int i = 0; i < CordSteps; i++) begin
      a = longint'({32'd0, ddo_pkg::atan_bam(i[4:0])});
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= a;
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += a;
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic pose_t advance_pose(sample_t s);
    pose_t p;
    longint len_l, len_r, travel, cs, sn;
    logic [31:0] dl, dr, dth, half;
    logic [63:0] prod;
    if (s.func == FUNC_START) begin
      x_pos = 0; y_pos = 0; heading_pos = '0;
    end else begin
      dl = s.left_count - prev_left;
      dr = s.right_count - prev_right;
      len_l = longint'(signed'(dl)) * longint'({32'd0, left_tick});
      len_r = longint'(signed'(dr)) * longint'({32'd0, right_tick});
      prod = (64'(len_l) - 64'(len_r)) * {32'd0, turn_gain};
      dth = prod[63:32];
      half = {dth[31], dth[31:1]};
      travel = ((len_l >>> 8) + (len_r >>> 8)) >>> 1;
      rotate(heading_pos + half, cs, sn);
      x_pos = sat_add(x_pos, scale_q30(travel, cs));
      y_pos = sat_add(y_pos, scale_q30(travel, sn));
      heading_pos += dth;
    end
    prev_left = s.left_count;
    prev_right = s.right_count;
    p.pos_x = x_pos[PoseW-1:0];
    p.pos_y = y_pos[PoseW-1:0];
    p.heading = heading_pos;
    return p;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        pose_q.push_back(advance_pose('{in_if.func, in_if.left_count, in_if.right_count}));
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          sample_t s;
          s = sample_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.func <= s.func;
          in_if.left_count <= s.left_count;
          in_if.right_count <= s.right_count;
          send_gap <= rand_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pose_q.size() == 0) begin
          report("unexpected result", 64'(out_if.heading), 64'd0);
        end else begin
          pose_t w;
          w = pose_q.pop_front();
          if (out_if.pos_x !== w.pos_x) report("pos_x", 64'(out_if.pos_x), 64'(w.pos_x));
          if (out_if.pos_y !== w.pos_y) report("pos_y", 64'(out_if.pos_y), 64'(w.pos_y));
          if (out_if.heading !== w.heading) begin
            report("heading", 64'(out_if.heading), 64'(w.heading));
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        recv_stall <= rand_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("** differential_drive_odometry_unit: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [ddo_pkg::IdxW-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      ddo_pkg::REG_LEFT_TICK:  left_tick = val;
      ddo_pkg::REG_RIGHT_TICK: right_tick = val;
      ddo_pkg::REG_TURN_GAIN:  turn_gain = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || in_if.valid || pose_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic push(logic func, logic [31:0] lc, logic [31:0] rc);
    sample_q.push_back('{func, lc, rc});
    gen_left = lc;
    gen_right = rc;
  endtask

  // Mostly plausible motion; some starts and some wild counts
  task automatic push_random(int n);
    int r, span;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      span = ($urandom_range(0, 9) == 0) ? 200000 : 3000;
      if (r < 4) push(FUNC_START, $urandom, $urandom);
      else if (r < 12) push(FUNC_STEP, $urandom, $urandom);
      else push(FUNC_STEP, gen_left + $urandom_range(0, 2 * span) - span,
                gen_right + $urandom_range(0, 2 * span) - span);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.func = FUNC_START;
    in_if.left_count = '0;
    in_if.right_count = '0;
    out_if.ready = 1'b0;
    left_tick = ddo_pkg::LEFT_TICK_RST;
    right_tick = ddo_pkg::RIGHT_TICK_RST;
    turn_gain = ddo_pkg::TURN_GAIN_RST;
    x_pos = 0; y_pos = 0;
    heading_pos = '0; prev_left = '0; prev_right = '0;
    n_errors = 0;
    idle_cycles = 0;
    no_idle = 0;
    send_gap = 0;
    recv_stall = 0;
    gen_left = '0;
    gen_right = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset values, wraps, large turns, extremes
    push(FUNC_STEP, 32'd100, 32'd100);
    push(FUNC_STEP, 32'd150, 32'd120);
    push(FUNC_START, 32'd0, 32'd0);
    push(FUNC_STEP, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push(FUNC_STEP, 32'h80000000, 32'h80000000);
    push(FUNC_STEP, 32'h80000000, 32'h7FFFFFFF);
    push(FUNC_STEP, 32'h00000000, 32'h80000000);
    push(FUNC_STEP, 32'hFFFFFFFF, 32'h00000001);
    push(FUNC_STEP, 32'h40000000, 32'hC0000000);
    push(FUNC_START, 32'hFFFFFFFF, 32'hFFFFFFFF);
    push(FUNC_STEP, 32'h00001000, 32'hFFFFF000);
    push(FUNC_STEP, 32'h00000000, 32'h00000000);
    push(FUNC_STEP, 32'hA5A5A5A5, 32'h5A5A5A5A);
    push(FUNC_STEP, 32'h5A5A5A5A, 32'hA5A5A5A5);
    push(FUNC_START, 32'h12345678, 32'h87654321);
    push_random(235);
    drain();

    // Zero lengths and gain: no motion, no turn
    write_reg(ddo_pkg::REG_LEFT_TICK, 32'd0);
    write_reg(ddo_pkg::REG_RIGHT_TICK, 32'd0);
    write_reg(ddo_pkg::REG_TURN_GAIN, 32'd0);
    no_idle = 1;
    push_random(150);
    drain();

    // Full-scale registers: drive the pose into saturation
    write_reg(ddo_pkg::REG_LEFT_TICK, 32'hFFFFFFFF);
    write_reg(ddo_pkg::REG_RIGHT_TICK, 32'hFFFFFFFF);
    write_reg(ddo_pkg::REG_TURN_GAIN, 32'hFFFFFFFF);
    no_idle = 0;
    push(FUNC_START, 32'd0, 32'd0);
    for (int k = 0; k < 8; k++) push(FUNC_STEP, gen_left + 32'h7FFFFFFF, gen_right + 32'h7FFFFFFF);
    for (int k = 0; k < 8; k++) push(FUNC_STEP, gen_left - 32'h7FFFFFFF, gen_right + 32'h00010000);
    push_random(200);
    drain();

    // Unused index must leave the registers alone
    write_reg(REG_UNUSED, 32'h00000000);
    write_reg(ddo_pkg::REG_LEFT_TICK, 32'd52000000);
    write_reg(ddo_pkg::REG_RIGHT_TICK, 32'd53000000);
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    push_random(300);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_reg(ddo_pkg::REG_LEFT_TICK, $urandom);
      write_reg(ddo_pkg::REG_RIGHT_TICK, $urandom);
      write_reg(ddo_pkg::REG_TURN_GAIN, $urandom >> $urandom_range(0, 24));
      no_idle = (ph == 1);
      push(FUNC_START, gen_left, gen_right);
      push_random(200);
      drain();
    end

    if (n_errors == 0) begin
      $display("** differential_drive_odometry_unit: PASSED **");
    end else begin
      $display("** differential_drive_odometry_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
